### sv/gdkw_pkg.sv
// Package for the Gaussian density kernel weight: constants and the 2^-k/16 table.
`timescale 1ns / 1ps
`default_nettype none
package gdkw_pkg;

  localparam int R2_BITS   = 52;
  localparam int Q_BITS    = 22;  // 6 integer and 16 fraction bits of d2 / r2
  localparam int REM_BITS  = R2_BITS + 6;
  localparam int W_BITS    = 32;
  localparam int E_BITS    = 31;

  localparam logic [16:0] BETA_HALF_Q16       = 17'd63996;
  localparam logic [16:0] BETA_HALF_LOG2E_Q16 = 17'd92327;
  localparam logic [22:0] RATIO_LIMIT_Q16     = 23'd2097152;
  localparam logic signed [31:0] A_Q30  = 32'sd621360650;
  localparam logic [29:0]        AK_Q30 = 30'd724067813;
  localparam logic signed [31:0] W_BASE = A_Q30 - 32'sd724067813;

  typedef logic [E_BITS-1:0] frac_t;

  // 2^(-k/16) in Q30 for k = 0..16.
  function automatic frac_t pow2_frac(input logic [4:0] k);
    frac_t v;
    case (k)
      5'd0:  v = 31'd1073741824;
      5'd1:  v = 31'd1028218694;
      5'd2:  v = 31'd984625594;
      5'd3:  v = 31'd942880698;
      5'd4:  v = 31'd902905642;
      5'd5:  v = 31'd864625411;
      5'd6:  v = 31'd827968156;
      5'd7:  v = 31'd792864945;
      5'd8:  v = 31'd759250125;
      5'd9:  v = 31'd727060410;
      5'd10: v = 31'd696235434;
      5'd11: v = 31'd666717340;
      5'd12: v = 31'd638450708;
      5'd13: v = 31'd611382493;
      5'd14: v = 31'd585461872;
      5'd15: v = 31'd560640217;
      5'd16: v = 31'd536870912;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### sv/gaussian_density_kernel_weight.sv
// Top level: pipelined Gaussian photon density kernel weight.
//
//   channel | direction | words                                         | handshake
//   in      | input     | query_x/y/z, photon_x/y/z, radius_squared      | in_valid / in_stall
//   out     | output    | weight                                        | out_valid / out_stall
//
// One word enters per cycle while in_stall is low, so a new word is taken before earlier ones finish.
// The depth is set by the 22-stage restoring divider that forms d2 / r2, one quotient
// bit per stage. Reset clears every valid bit; data registers are not reset.
// When a finished weight is held by out_stall, the whole pipeline holds and in_stall
// rises, so no word is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_density_kernel_weight #(
  parameter int COORD_BITS = 24
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire signed [COORD_BITS-1:0]    query_x,
  input  wire signed [COORD_BITS-1:0]    query_y,
  input  wire signed [COORD_BITS-1:0]    query_z,
  input  wire signed [COORD_BITS-1:0]    photon_x,
  input  wire signed [COORD_BITS-1:0]    photon_y,
  input  wire signed [COORD_BITS-1:0]    photon_z,
  input  wire [gdkw_pkg::R2_BITS-1:0]    radius_squared,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic signed [gdkw_pkg::W_BITS-1:0] weight
);
  import gdkw_pkg::*;

  localparam int MW = COORD_BITS + 1;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: coordinate differences as magnitudes.
  logic signed [MW-1:0] dx, dy, dz;
  logic [MW-1:0] ax, ay, az;
  assign dx = MW'(query_x) - MW'(photon_x);
  assign dy = MW'(query_y) - MW'(photon_y);
  assign dz = MW'(query_z) - MW'(photon_z);
  assign ax = dx[MW-1] ? MW'(-dx) : MW'(dx);
  assign ay = dy[MW-1] ? MW'(-dy) : MW'(dy);
  assign az = dz[MW-1] ? MW'(-dz) : MW'(dz);

  logic v1, big1;
  logic [31:0] mx1, my1, mz1;
  logic [R2_BITS-1:0] r2_1;

  // Stage 2: squares.
  logic v2, big2;
  logic [63:0] sqx2, sqy2, sqz2;
  logic [R2_BITS-1:0] r2_2;

  // Stage 3: saturated sum, zero radius taken as one.
  logic v3;
  logic [65:0] sum_full;
  logic [63:0] d2_3;
  logic [R2_BITS-1:0] r2_3;
  assign sum_full = 66'(sqx2) + 66'(sqy2) + 66'(sqz2);

  // Stage 4 feeds the divider: overflow when d2 / r2 reaches 64.
  logic [REM_BITS+5:0] r2_x64;
  assign r2_x64 = {6'd0, r2_3, 6'd0};

  logic               dv   [0:Q_BITS];
  logic               dovf [0:Q_BITS];
  logic [REM_BITS-1:0] drem [0:Q_BITS];
  logic [R2_BITS-1:0] dden [0:Q_BITS];
  logic [Q_BITS-1:0]  dq   [0:Q_BITS];

  logic [REM_BITS-1:0] rem_next [0:Q_BITS-1];
  logic                ge       [0:Q_BITS-1];

  always_comb begin
    for (int k = 0; k < Q_BITS; k++) begin
      logic [REM_BITS-1:0] den;
      logic [REM_BITS-1:0] r;
      den = {1'b0, dden[k], 5'd0};
      ge[k] = drem[k] >= den;
      r = ge[k] ? drem[k] - den : drem[k];
      rem_next[k] = {r[REM_BITS-2:0], 1'b0};
    end
  end

  // Exponential stages.
  logic [Q_BITS-1:0] xq;
  logic [38:0] s_prod, y_prod;
  assign xq     = dq[Q_BITS];
  assign s_prod = 39'(xq) * 39'(BETA_HALF_Q16);
  assign y_prod = 39'(xq) * 39'(BETA_HALF_LOG2E_Q16);

  logic v27, zero27;
  logic [22:0] y27;

  logic [4:0] idx;
  frac_t t_lo, t_hi;
  logic [25:0] tdiff;
  assign idx   = {1'b0, y27[15:12]};
  assign t_lo  = pow2_frac(idx);
  assign t_hi  = pow2_frac(idx + 5'd1);
  assign tdiff = 26'(t_lo - t_hi);

  logic v28, zero28;
  logic [6:0] n28;
  frac_t t28;
  logic [37:0] prod28;

  frac_t vint;
  assign vint = t28 - E_BITS'(prod28 >> 12);

  logic v29;
  frac_t e29;

  logic v30;
  logic [60:0] p30;
  logic [60:0] p_round;
  assign p_round = p30 + 61'(1 << 29);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      for (int k = 0; k <= Q_BITS; k++) dv[k] <= 1'b0;
      v27 <= 1'b0; v28 <= 1'b0; v29 <= 1'b0; v30 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      dv[0] <= v3;
      for (int k = 0; k < Q_BITS; k++) dv[k+1] <= dv[k];
      v27 <= dv[Q_BITS];
      v28 <= v27;
      v29 <= v28;
      v30 <= v29;
      out_valid <= v30;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mx1  <= 32'(ax);
      my1  <= 32'(ay);
      mz1  <= 32'(az);
      big1 <= ((64'(ax) >> 31) != 64'd0) || ((64'(ay) >> 31) != 64'd0) ||
              ((64'(az) >> 31) != 64'd0);
      r2_1 <= radius_squared;

      sqx2 <= 64'(mx1) * 64'(mx1);
      sqy2 <= 64'(my1) * 64'(my1);
      sqz2 <= 64'(mz1) * 64'(mz1);
      big2 <= big1;
      r2_2 <= r2_1;

      d2_3 <= (big2 || sum_full > 66'(64'h8000_0000_0000_0000)) ?
              64'h8000_0000_0000_0000 : sum_full[63:0];
      r2_3 <= (r2_2 == '0) ? R2_BITS'(1) : r2_2;

      dovf[0] <= {6'd0, d2_3} >= 70'(r2_x64);
      drem[0] <= d2_3[REM_BITS-1:0];
      dden[0] <= r2_3;
      dq[0]   <= '0;
      for (int k = 0; k < Q_BITS; k++) begin
        dovf[k+1] <= dovf[k];
        drem[k+1] <= rem_next[k];
        dden[k+1] <= dden[k];
        dq[k+1]   <= {dq[k][Q_BITS-2:0], ge[k]};
      end

      zero27 <= dovf[Q_BITS] || (s_prod[38:16] > RATIO_LIMIT_Q16);
      y27    <= y_prod[38:16];

      zero28 <= zero27 || (y27[22:16] > 7'd30);
      n28    <= y27[22:16];
      t28    <= t_lo;
      prod28 <= 38'(tdiff) * 38'(y27[11:0]);

      e29 <= zero28 ? '0 : (vint >> n28[4:0]);

      p30 <= 61'(AK_Q30) * 61'(e29);

      weight <= W_BASE + 32'(p_round >> 30);
    end
  end

endmodule
`default_nettype wire

### sv/gdkw_checker.sv
// Port-level checks for the kernel weight block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module gdkw_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [31:0] weight
);

  // A held word keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(weight))
    else $error("weight changed while stalled");

  // The input only stalls behind a held output word.
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // The weight lies between its far-field floor and the value at zero distance.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(weight) >= -32'sd102707163) &&
                  ($signed(weight) <= 32'sd621360650))
    else $error("weight out of range");

  // Nothing comes out right after reset.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind gaussian_density_kernel_weight gdkw_checker u_gdkw_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .weight   (weight)
);
`default_nettype wire
